>>> rtl/qdse_pkg.sv
// qdse_pkg: shared types, mode codes and constants for the qr data segment bit encoder
// no dependencies

package qdse_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;
  localparam logic [1:0] MODE_KANJI   = 2'd3;

  localparam logic [15:0] KANJI_LO1   = 16'd33088;
  localparam logic [15:0] KANJI_HI1   = 16'd40956;
  localparam logic [15:0] KANJI_LO2   = 16'd57408;
  localparam logic [15:0] KANJI_HI2   = 16'd60351;
  localparam logic [15:0] KANJI_BASE2 = 16'd49472;

  localparam logic [15:0] DIGIT_OFFSET  = 16'd48;
  localparam logic [15:0] LETTER_OFFSET = 16'd55;

  localparam logic [3:0] LEN_NUM1  = 4'd4;
  localparam logic [3:0] LEN_ALN1  = 4'd6;
  localparam logic [3:0] LEN_NUM2  = 4'd7;
  localparam logic [3:0] LEN_BYTE  = 4'd8;
  localparam logic [3:0] LEN_NUM3  = 4'd10;
  localparam logic [3:0] LEN_ALN2  = 4'd11;
  localparam logic [3:0] LEN_KANJI = 4'd13;

  // one classified character between front and back
  typedef struct packed {
    logic [1:0]  mode;
    logic        fin;
    logic [12:0] val;
  } qdse_entry_t;

  function automatic logic [5:0] alnum_code(input logic [15:0] c);
    logic [15:0] t;
    t = 16'd1;
    if (c >= 16'd48 && c <= 16'd57) begin
      t = c - DIGIT_OFFSET;
    end else if (c >= 16'd65 && c <= 16'd90) begin
      t = c - LETTER_OFFSET;
    end else begin
      unique case (c)
        16'd32:  t = 16'd36;
        16'd36:  t = 16'd37;
        16'd37:  t = 16'd38;
        16'd42:  t = 16'd39;
        16'd43:  t = 16'd40;
        16'd45:  t = 16'd41;
        16'd46:  t = 16'd42;
        16'd47:  t = 16'd43;
        16'd58:  t = 16'd44;
        default: t = 16'd1;
      endcase
    end
    return t[5:0];
  endfunction

endpackage

>>> rtl/qdse_front.sv
// qdse_front: classifies one input character for the current mode
// depends on qdse_pkg

module qdse_front import qdse_pkg::*; (
  input  logic [1:0]  mode,
  input  logic [15:0] char_code,
  input  logic        is_final,
  output qdse_entry_t entry,
  output logic        keep
);

  logic [15:0] r1;
  logic [15:0] r2;
  logic [15:0] r;
  logic        in1;
  logic        in2;
  logic [13:0] kval;
  logic [15:0] dsub;
  logic [3:0]  digit;

  assign in1  = (char_code >= KANJI_LO1) && (char_code <= KANJI_HI1);
  assign in2  = (char_code >= KANJI_LO2) && (char_code <= KANJI_HI2);
  assign r1   = char_code - KANJI_LO1;
  assign r2   = char_code - KANJI_BASE2;
  assign r    = in1 ? r1 : r2;
  // msb * 192 + lsb
  assign kval = {1'b0, r[13:8], 7'b0} + {2'b0, r[13:8], 6'b0} + {6'b0, r[7:0]};
  assign dsub = char_code - DIGIT_OFFSET;
  assign digit = (char_code >= 16'd48 && char_code <= 16'd57) ? dsub[3:0] : 4'd0;

  always_comb begin
    entry.mode = mode;
    entry.fin  = is_final;
    entry.val  = '0;
    keep       = 1'b1;
    unique case (mode)
      MODE_NUMERIC: entry.val = {9'b0, digit};
      MODE_ALNUM:   entry.val = {7'b0, alnum_code(char_code)};
      MODE_BYTE:    entry.val = {5'b0, char_code[7:0]};
      MODE_KANJI: begin
        entry.val = kval[12:0];
        keep      = in1 || in2;
      end
      default:      entry.val = '0;
    endcase
  end

endmodule

>>> rtl/qdse_queue.sv
// qdse_queue: small fifo of classified characters between front and back
// depends on qdse_pkg

module qdse_queue import qdse_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  qdse_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        nonempty,
  output qdse_entry_t head
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  qdse_entry_t      slots [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/qdse_back.sv
// qdse_back: groups classified characters using the pending state, output register
// depends on qdse_pkg

module qdse_back import qdse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        head_valid,
  input  qdse_entry_t head,
  output logic        pop,
  output logic [12:0] group_bits,
  output logic [3:0]  group_length,
  output logic        segment_end,
  output logic        out_valid,
  input  logic        out_stall
);

  logic [6:0]  pending_value;
  logic [1:0]  pending_count;
  logic [6:0]  pending_value_next;
  logic [1:0]  pending_count_next;
  logic        emit;
  logic [12:0] bits;
  logic [3:0]  len;
  logic [9:0]  acc;
  logic [2:0]  cnt;
  logic [10:0] pair;

  assign pop  = head_valid && (!out_valid || !out_stall);
  assign acc  = 10'(pending_value) * 10'd10 + 10'(head.val[3:0]);
  assign cnt  = {1'b0, pending_count} + 3'd1;
  assign pair = 11'(pending_value) * 11'd45 + 11'(head.val[5:0]);

  always_comb begin
    emit               = 1'b0;
    bits               = '0;
    len                = LEN_BYTE;
    pending_value_next = pending_value;
    pending_count_next = pending_count;
    unique case (head.mode)
      MODE_NUMERIC: begin
        if (cnt >= 3'd3 || head.fin) begin
          emit               = 1'b1;
          bits               = {3'b0, acc};
          len                = (cnt >= 3'd3) ? LEN_NUM3 : ((cnt == 3'd2) ? LEN_NUM2 : LEN_NUM1);
          pending_value_next = '0;
          pending_count_next = '0;
        end else begin
          pending_value_next = acc[6:0];
          pending_count_next = cnt[1:0];
        end
      end
      MODE_ALNUM: begin
        if (pending_count != '0) begin
          emit               = 1'b1;
          bits               = {2'b0, pair};
          len                = LEN_ALN2;
          pending_value_next = '0;
          pending_count_next = '0;
        end else if (head.fin) begin
          emit = 1'b1;
          bits = {7'b0, head.val[5:0]};
          len  = LEN_ALN1;
        end else begin
          pending_value_next = {1'b0, head.val[5:0]};
          pending_count_next = 2'd1;
        end
      end
      MODE_BYTE: begin
        emit = 1'b1;
        bits = {5'b0, head.val[7:0]};
        len  = LEN_BYTE;
      end
      MODE_KANJI: begin
        emit = 1'b1;
        bits = head.val;
        len  = LEN_KANJI;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_value <= '0;
      pending_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (clear) begin
        pending_value <= '0;
        pending_count <= '0;
      end else if (pop) begin
        pending_value <= pending_value_next;
        pending_count <= pending_count_next;
      end
      if (pop) begin
        out_valid <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      group_bits   <= bits;
      group_length <= len;
      segment_end  <= head.fin;
    end
  end

endmodule

>>> rtl/qr_data_segment_bit_encoder.sv
// qr_data_segment_bit_encoder: top level, register port, front, queue and back
// depends on qdse_pkg, qdse_front, qdse_queue, qdse_back
//
// usage
// - input channel: char_code and is_final with in_valid / in_stall; one character per beat
// - output channel: group_bits, group_length, segment_end with out_valid / out_stall;
//   zero or one group per input beat, in input order
// - encode_mode is written over the apb port at address 0; a write also drops any
//   partial numeric or alphanumeric group; write only while the block is idle
// - an accepted character is written into the queue, then grouped by the back and held in its output register
// - throughput: one character per cycle while out_stall is low, set by the grouping step in the back
// - the front classifies and pushes into a two-entry queue; in_stall is high only when
//   that queue is full, which happens when the receiver holds out_stall
// - an out-of-range kanji code is accepted and gives no group
// - under out_stall the output register holds its beat and the queue fills behind it
// - reset clears the mode to numeric, the pending group, the queue and out_valid

module qr_data_segment_bit_encoder import qdse_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [15:0] char_code,
  input  logic        is_final,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [12:0] group_bits,
  output logic [3:0]  group_length,
  output logic        segment_end,
  output logic        out_valid,
  input  logic        out_stall
);

  logic [1:0]  encode_mode;
  logic        cfg_write;
  qdse_entry_t front_entry;
  logic        front_keep;
  logic        q_full;
  logic        q_nonempty;
  qdse_entry_t q_head;
  logic        q_push;
  logic        q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {30'b0, encode_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= MODE_NUMERIC;
    end else if (cfg_write) begin
      encode_mode <= pwdata[1:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && front_keep;

  qdse_front u_front (
    .mode      (encode_mode),
    .char_code (char_code),
    .is_final  (is_final),
    .entry     (front_entry),
    .keep      (front_keep)
  );

  qdse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  qdse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .head_valid   (q_nonempty),
    .head         (q_head),
    .pop          (q_pop),
    .group_bits   (group_bits),
    .group_length (group_length),
    .segment_end  (segment_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule
